// File: rtl/core/evt_pkg.sv
// Shared constants, types and the quarter-wave sine table for the Euler vertex transform.
// Used by every module of the block; depends on nothing else.
package evt_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int COORD_WIDTH      = 16;

  localparam int CFG_REG_W   = 16;
  localparam int ANGLE_W     = 16;
  localparam int CFG_DATA_W  = 3 * ANGLE_W;
  localparam int CFG_INDEX_W = 3;
  localparam int FRAC_BITS   = 8;
  localparam int TRIG_BITS   = 14;
  localparam int NUM_STAGES  = 5;

  // The two top angle bits select the quadrant; the rest is the phase inside it.
  localparam int ANGLE_FRAC_W = ANGLE_W - 2;

  // Table entries run 0..1.0 in Q1.14, so they need TRIG_BITS+1 bits unsigned.
  localparam int TAB_W     = TRIG_BITS + 1;
  localparam int TRIG_W    = TAB_W + 1;
  localparam int TAB_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TAB_BITS  = (SINE_TABLE_DEPTH + 1) * TAB_W;

  // Datapath widths: each rotation keeps the full sum of two products.
  localparam int P0_W    = COORD_WIDTH + CFG_REG_W;
  localparam int V_W     = P0_W - FRAC_BITS + 1;
  localparam int PR1_W   = V_W + TRIG_W;
  localparam int R1_W    = PR1_W + 1 - TRIG_BITS;
  localparam int PR2_W   = R1_W + TRIG_W;
  localparam int R2_W    = PR2_W + 1 - TRIG_BITS;
  localparam int PR3_W   = R2_W + TRIG_W;
  localparam int R3_W    = PR3_W + 1 - TRIG_BITS;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1 <<< 30;

  localparam logic [CFG_REG_W-1:0] SCALE_RESET  = CFG_REG_W'(1 << FRAC_BITS);
  localparam logic [CFG_REG_W-1:0] OFFSET_RESET = '0;
  localparam logic [CFG_DATA_W-1:0] ANGLE_RESET = '0;

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCALE_X  = CFG_INDEX_W'(0),
    REG_SCALE_Y  = CFG_INDEX_W'(1),
    REG_SCALE_Z  = CFG_INDEX_W'(2),
    REG_OFFSET_X = CFG_INDEX_W'(3),
    REG_OFFSET_Y = CFG_INDEX_W'(4),
    REG_OFFSET_Z = CFG_INDEX_W'(5),
    REG_ANGLES   = CFG_INDEX_W'(6)
  } evt_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cz;
  } evt_trig_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } evt_en_t;

  // Signed division that truncates toward zero, worked out bit by bit on the magnitudes.
  function automatic longint div_trunc(longint num, longint den);
    logic [63:0] n_mag;
    logic [63:0] d_mag;
    logic [63:0] quo;
    logic [63:0] rem;
    logic        neg;
    neg   = (num < 0) ^ (den < 0);
    n_mag = (num < 0) ? 64'(-num) : 64'(num);
    d_mag = (den < 0) ? 64'(-den) : 64'(den);
    quo   = '0;
    rem   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n_mag[b]};
      if (rem >= d_mag) begin
        rem    = rem - d_mag;
        quo[b] = 1'b1;
      end
    end
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  // Built at elaboration: eleven-term Taylor series in Q30, rounded to Q14.
  function automatic logic [TAB_BITS-1:0] build_sine_tab();
    logic [TAB_BITS-1:0] tab;
    longint t;
    longint t2;
    longint term;
    longint sum;
    longint r;
    int     i;
    int     k;
    tab = '0;
    for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t    = div_trunc(HALF_PI_Q30 * longint'(i), longint'(SINE_TABLE_DEPTH));
      t2   = div_trunc(t * t, Q30_ONE);
      term = t;
      sum  = t;
      for (k = 1; k <= 10; k++) begin
        term = -div_trunc(term * t2, Q30_ONE);
        term = div_trunc(term, longint'((2 * k) * (2 * k + 1)));
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + (64'sd1 <<< 15)) >>> 16;
      if (r > (64'sd1 <<< TRIG_BITS)) begin
        r = 64'sd1 <<< TRIG_BITS;
      end
      tab[i*TAB_W +: TAB_W] = r[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam logic [TAB_BITS-1:0] SINE_TAB = build_sine_tab();

endpackage

// File: rtl/core/euler_vertex_transform_top.sv
// Top level of the Euler vertex transform: configuration registers, trig lookup and
// pipeline control. Depends on evt_pkg, evt_sincos, evt_front and evt_back.
//
// Usage:
//   Vertices enter on the input channel (in_valid_i / in_stall_o) as three signed
//   Q8.8 coordinates; transformed vertices leave on the output channel
//   (out_valid_o / out_stall_i) with a flag that marks a clipped coordinate.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes scale, offset
//   and the packed rotation angles by register index; it is always ready and an
//   unknown index is ignored. Write it only while no vertex is in flight.
//   An accepted input beat reaches its output beat through the five register stages:
//   scale multiply, offset add with z products, z rotation with x products,
//   x rotation with y products, y rotation with saturation into the output
//   register. Throughput is one vertex per cycle while the receiver does not stall.
//   When the receiver stalls, the output beat holds and earlier stages keep
//   filling their empty slots; in_stall_o rises only when all five are full.
//   Reset empties the pipeline, sets every scale to 1.0 and clears the offsets
//   and angles. The sine and cosine values are registered once per cycle from
//   the angle register.
module euler_vertex_transform_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [evt_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [evt_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [evt_pkg::COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [evt_pkg::COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [evt_pkg::COORD_WIDTH-1:0] vertex_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [evt_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [evt_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic signed [evt_pkg::COORD_WIDTH-1:0] out_z_o,
  output logic                                   saturated_o
);

  localparam int NS = evt_pkg::NUM_STAGES;
  localparam int RW = evt_pkg::CFG_REG_W;
  localparam int AW = evt_pkg::ANGLE_W;

  logic [RW-1:0]                     scale_x_q, scale_y_q, scale_z_q;
  logic [RW-1:0]                     offset_x_q, offset_y_q, offset_z_q;
  logic [evt_pkg::CFG_DATA_W-1:0]    angles_q;
  evt_pkg::evt_trig_t                trig_d, trig_q;
  logic [NS-1:0]                     vld_q, vld_d, rdy;
  evt_pkg::evt_en_t                  en;
  logic signed [evt_pkg::PR1_W-1:0]  x_cz, y_sz, x_sz, y_cz;
  logic signed [evt_pkg::V_W-1:0]    z1;
  logic [evt_pkg::COORD_WIDTH-1:0]   res_x, res_y, res_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q  <= evt_pkg::SCALE_RESET;
      scale_y_q  <= evt_pkg::SCALE_RESET;
      scale_z_q  <= evt_pkg::SCALE_RESET;
      offset_x_q <= evt_pkg::OFFSET_RESET;
      offset_y_q <= evt_pkg::OFFSET_RESET;
      offset_z_q <= evt_pkg::OFFSET_RESET;
      angles_q   <= evt_pkg::ANGLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (evt_pkg::evt_reg_e'(cfg_index_i))
        evt_pkg::REG_SCALE_X:  scale_x_q  <= cfg_data_i[RW-1:0];
        evt_pkg::REG_SCALE_Y:  scale_y_q  <= cfg_data_i[RW-1:0];
        evt_pkg::REG_SCALE_Z:  scale_z_q  <= cfg_data_i[RW-1:0];
        evt_pkg::REG_OFFSET_X: offset_x_q <= cfg_data_i[RW-1:0];
        evt_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data_i[RW-1:0];
        evt_pkg::REG_OFFSET_Z: offset_z_q <= cfg_data_i[RW-1:0];
        evt_pkg::REG_ANGLES:   angles_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bits 15:0 hold the x angle, 31:16 the y angle and 47:32 the z angle.
  evt_sincos u_sincos_x (
    .angle_i (angles_q[0*AW +: AW]),
    .sin_o   (trig_d.sx),
    .cos_o   (trig_d.cx)
  );

  evt_sincos u_sincos_y (
    .angle_i (angles_q[1*AW +: AW]),
    .sin_o   (trig_d.sy),
    .cos_o   (trig_d.cy)
  );

  evt_sincos u_sincos_z (
    .angle_i (angles_q[2*AW +: AW]),
    .sin_o   (trig_d.sz),
    .cos_o   (trig_d.cz)
  );

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
    en.s1 = rdy[0];
    en.s2 = rdy[1];
    en.s3 = rdy[2];
    en.s4 = rdy[3];
    en.s5 = rdy[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  evt_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .vertex_x_i (vertex_x_i),
    .vertex_y_i (vertex_y_i),
    .vertex_z_i (vertex_z_i),
    .scale_x_i  ($signed(scale_x_q)),
    .scale_y_i  ($signed(scale_y_q)),
    .scale_z_i  ($signed(scale_z_q)),
    .offset_x_i ($signed(offset_x_q)),
    .offset_y_i ($signed(offset_y_q)),
    .offset_z_i ($signed(offset_z_q)),
    .trig_i     (trig_q),
    .x_cz_o     (x_cz),
    .y_sz_o     (y_sz),
    .x_sz_o     (x_sz),
    .y_cz_o     (y_cz),
    .z1_o       (z1)
  );

  evt_back u_back (
    .clk_i       (clk_i),
    .en_i        (en),
    .trig_i      (trig_q),
    .x_cz_i      (x_cz),
    .y_sz_i      (y_sz),
    .x_sz_i      (x_sz),
    .y_cz_i      (y_cz),
    .z1_i        (z1),
    .out_x_o     (res_x),
    .out_y_o     (res_y),
    .out_z_o     (res_z),
    .saturated_o (saturated_o)
  );

  assign out_x_o = $signed(res_x);
  assign out_y_o = $signed(res_y);
  assign out_z_o = $signed(res_z);

`ifndef SYNTHESIS
  // Input backpressure only when no stage has a free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while the pipeline has an empty stage");

  // An accepted beat always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted input beat lost at the first stage");

  // A clipped result carries at least one coordinate at a range limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (res_x == evt_pkg::COORD_MAX || res_x == evt_pkg::COORD_MIN ||
       res_y == evt_pkg::COORD_MAX || res_y == evt_pkg::COORD_MIN ||
       res_z == evt_pkg::COORD_MAX || res_z == evt_pkg::COORD_MIN))
    else $error("saturation flag set with no coordinate at a limit");
`endif

endmodule

// File: rtl/core/evt_sincos.sv
// Sine and cosine of one 16-bit binary angle from the quarter-wave table.
// Depends on evt_pkg for the table and widths.
module evt_sincos (
  input  logic [evt_pkg::ANGLE_W-1:0]       angle_i,
  output logic signed [evt_pkg::TRIG_W-1:0] sin_o,
  output logic signed [evt_pkg::TRIG_W-1:0] cos_o
);

  localparam int SCALED_W = evt_pkg::ANGLE_FRAC_W + evt_pkg::TAB_IDX_W;

  function automatic logic signed [evt_pkg::TRIG_W-1:0] lookup(
    input logic [evt_pkg::ANGLE_W-1:0] a
  );
    logic [SCALED_W-1:0]               scaled;
    logic [evt_pkg::TAB_IDX_W-1:0]     idx;
    logic [evt_pkg::TAB_IDX_W-1:0]     sel;
    logic [evt_pkg::TAB_W-1:0]         mag;
    logic signed [evt_pkg::TRIG_W-1:0] val;
    scaled = {{evt_pkg::TAB_IDX_W{1'b0}}, a[evt_pkg::ANGLE_FRAC_W-1:0]}
             * SCALED_W'(evt_pkg::SINE_TABLE_DEPTH);
    idx = scaled[evt_pkg::ANGLE_FRAC_W +: evt_pkg::TAB_IDX_W];
    // Odd quadrants read the table backward.
    sel = a[evt_pkg::ANGLE_FRAC_W]
          ? evt_pkg::TAB_IDX_W'(evt_pkg::SINE_TABLE_DEPTH) - idx : idx;
    mag = evt_pkg::SINE_TAB[int'(sel) * evt_pkg::TAB_W +: evt_pkg::TAB_W];
    val = $signed({1'b0, mag});
    return a[evt_pkg::ANGLE_FRAC_W+1] ? -val : val;
  endfunction

  localparam logic [evt_pkg::ANGLE_W-1:0] QUARTER_TURN =
    evt_pkg::ANGLE_W'(1 << evt_pkg::ANGLE_FRAC_W);

  assign sin_o = lookup(angle_i);
  assign cos_o = lookup(angle_i + QUARTER_TURN);

endmodule

// File: rtl/core/evt_front.sv
// Front pipeline stages: per-axis scale multiply, offset add and the z-axis products.
// Depends on evt_pkg for widths, the trig struct and the stage enables.
module evt_front (
  input  logic                                    clk_i,
  input  evt_pkg::evt_en_t                        en_i,
  input  logic signed [evt_pkg::COORD_WIDTH-1:0]  vertex_x_i,
  input  logic signed [evt_pkg::COORD_WIDTH-1:0]  vertex_y_i,
  input  logic signed [evt_pkg::COORD_WIDTH-1:0]  vertex_z_i,
  input  logic signed [evt_pkg::CFG_REG_W-1:0]    scale_x_i,
  input  logic signed [evt_pkg::CFG_REG_W-1:0]    scale_y_i,
  input  logic signed [evt_pkg::CFG_REG_W-1:0]    scale_z_i,
  input  logic signed [evt_pkg::CFG_REG_W-1:0]    offset_x_i,
  input  logic signed [evt_pkg::CFG_REG_W-1:0]    offset_y_i,
  input  logic signed [evt_pkg::CFG_REG_W-1:0]    offset_z_i,
  input  evt_pkg::evt_trig_t                      trig_i,
  output logic signed [evt_pkg::PR1_W-1:0]        x_cz_o,
  output logic signed [evt_pkg::PR1_W-1:0]        y_sz_o,
  output logic signed [evt_pkg::PR1_W-1:0]        x_sz_o,
  output logic signed [evt_pkg::PR1_W-1:0]        y_cz_o,
  output logic signed [evt_pkg::V_W-1:0]          z1_o
);

  localparam int P0_W = evt_pkg::P0_W;
  localparam int V_W  = evt_pkg::V_W;
  localparam int EXT  = V_W - evt_pkg::CFG_REG_W;

  logic signed [P0_W-1:0] px_q, py_q, pz_q;
  logic signed [V_W-1:0]  vx_d, vy_d, vz_d;
  logic signed [evt_pkg::TRIG_W-1:0] sz, cz;
  logic signed [evt_pkg::PR1_W-1:0]  x_cz_q, y_sz_q, x_sz_q, y_cz_q;
  logic signed [V_W-1:0]  z1_q;

  assign sz = trig_i.sz;
  assign cz = trig_i.cz;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      px_q <= vertex_x_i * scale_x_i;
      py_q <= vertex_y_i * scale_y_i;
      pz_q <= vertex_z_i * scale_z_i;
    end
  end

  // Dropping the low fraction bits of the product is the floor shift.
  always_comb begin
    vx_d = $signed({px_q[P0_W-1], px_q[P0_W-1:evt_pkg::FRAC_BITS]})
           + $signed({{EXT{offset_x_i[evt_pkg::CFG_REG_W-1]}}, offset_x_i});
    vy_d = $signed({py_q[P0_W-1], py_q[P0_W-1:evt_pkg::FRAC_BITS]})
           + $signed({{EXT{offset_y_i[evt_pkg::CFG_REG_W-1]}}, offset_y_i});
    vz_d = $signed({pz_q[P0_W-1], pz_q[P0_W-1:evt_pkg::FRAC_BITS]})
           + $signed({{EXT{offset_z_i[evt_pkg::CFG_REG_W-1]}}, offset_z_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      x_cz_q <= vx_d * cz;
      y_sz_q <= vy_d * sz;
      x_sz_q <= vx_d * sz;
      y_cz_q <= vy_d * cz;
      z1_q   <= vz_d;
    end
  end

  assign x_cz_o = x_cz_q;
  assign y_sz_o = y_sz_q;
  assign x_sz_o = x_sz_q;
  assign y_cz_o = y_cz_q;
  assign z1_o   = z1_q;

endmodule

// File: rtl/core/evt_back.sv
// Back pipeline stages: z and x rotation sums, y rotation, saturation and the output register.
// Depends on evt_pkg for widths, the trig struct and the stage enables.
module evt_back (
  input  logic                                    clk_i,
  input  evt_pkg::evt_en_t                        en_i,
  input  evt_pkg::evt_trig_t                      trig_i,
  input  logic signed [evt_pkg::PR1_W-1:0]        x_cz_i,
  input  logic signed [evt_pkg::PR1_W-1:0]        y_sz_i,
  input  logic signed [evt_pkg::PR1_W-1:0]        x_sz_i,
  input  logic signed [evt_pkg::PR1_W-1:0]        y_cz_i,
  input  logic signed [evt_pkg::V_W-1:0]          z1_i,
  output logic [evt_pkg::COORD_WIDTH-1:0]         out_x_o,
  output logic [evt_pkg::COORD_WIDTH-1:0]         out_y_o,
  output logic [evt_pkg::COORD_WIDTH-1:0]         out_z_o,
  output logic                                    saturated_o
);

  localparam int TB    = evt_pkg::TRIG_BITS;
  localparam int PR1_W = evt_pkg::PR1_W;
  localparam int PR2_W = evt_pkg::PR2_W;
  localparam int PR3_W = evt_pkg::PR3_W;
  localparam int R1_W  = evt_pkg::R1_W;
  localparam int R2_W  = evt_pkg::R2_W;
  localparam int R3_W  = evt_pkg::R3_W;
  localparam int CW    = evt_pkg::COORD_WIDTH;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } clip_t;

  function automatic clip_t clip(input logic signed [R3_W-1:0] v);
    logic [R3_W-CW:0] top;
    clip_t            res;
    top     = v[R3_W-1:CW-1];
    res.sat = !((&top) || !(|top));
    if (!res.sat) begin
      res.val = v[CW-1:0];
    end else if (v[R3_W-1]) begin
      res.val = evt_pkg::COORD_MIN;
    end else begin
      res.val = evt_pkg::COORD_MAX;
    end
    return res;
  endfunction

  logic signed [evt_pkg::TRIG_W-1:0] sx, cx, sy, cy;
  logic signed [PR1_W:0]   x1_sum, y1_sum;
  logic signed [R1_W-1:0]  x1_d, y1_d, z1_ext;
  logic signed [PR2_W-1:0] y_cx_q, z_sx_q, y_sx_q, z_cx_q;
  logic signed [R1_W-1:0]  x1_q;
  logic signed [PR2_W:0]   y2_sum, z2_sum;
  logic signed [R2_W-1:0]  y2_d, z2_d;
  logic signed [PR3_W-1:0] z_sy_q, x_cy_q, z_cy_q, x_sy_q;
  logic signed [R2_W-1:0]  y2_q;
  logic signed [PR3_W:0]   x3_sum, z3_sum;
  logic signed [R3_W-1:0]  x3_d, z3_d, y3_ext;
  clip_t                   cx_res, cy_res, cz_res;
  logic [CW-1:0]           out_x_q, out_y_q, out_z_q;
  logic                    sat_q;

  assign sx = trig_i.sx;
  assign cx = trig_i.cx;
  assign sy = trig_i.sy;
  assign cy = trig_i.cy;

  // Rotation about z: the upper bits of each full-width sum are the floor shift.
  always_comb begin
    x1_sum = $signed({x_cz_i[PR1_W-1], x_cz_i}) - $signed({y_sz_i[PR1_W-1], y_sz_i});
    y1_sum = $signed({x_sz_i[PR1_W-1], x_sz_i}) + $signed({y_cz_i[PR1_W-1], y_cz_i});
    x1_d   = x1_sum[PR1_W:TB];
    y1_d   = y1_sum[PR1_W:TB];
    z1_ext = $signed({{(R1_W-evt_pkg::V_W){z1_i[evt_pkg::V_W-1]}}, z1_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      y_cx_q <= y1_d * cx;
      z_sx_q <= z1_ext * sx;
      y_sx_q <= y1_d * sx;
      z_cx_q <= z1_ext * cx;
      x1_q   <= x1_d;
    end
  end

  // Rotation about x.
  always_comb begin
    y2_sum = $signed({y_cx_q[PR2_W-1], y_cx_q}) - $signed({z_sx_q[PR2_W-1], z_sx_q});
    z2_sum = $signed({y_sx_q[PR2_W-1], y_sx_q}) + $signed({z_cx_q[PR2_W-1], z_cx_q});
    y2_d   = y2_sum[PR2_W:TB];
    z2_d   = z2_sum[PR2_W:TB];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      z_sy_q <= z2_d * sy;
      x_cy_q <= x1_q * cy;
      z_cy_q <= z2_d * cy;
      x_sy_q <= x1_q * sy;
      y2_q   <= y2_d;
    end
  end

  // Rotation about y, then saturation of all three coordinates.
  always_comb begin
    x3_sum = $signed({z_sy_q[PR3_W-1], z_sy_q}) + $signed({x_cy_q[PR3_W-1], x_cy_q});
    z3_sum = $signed({z_cy_q[PR3_W-1], z_cy_q}) - $signed({x_sy_q[PR3_W-1], x_sy_q});
    x3_d   = x3_sum[PR3_W:TB];
    z3_d   = z3_sum[PR3_W:TB];
    y3_ext = $signed({{(R3_W-R2_W){y2_q[R2_W-1]}}, y2_q});
    cx_res = clip(x3_d);
    cy_res = clip(y3_ext);
    cz_res = clip(z3_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      out_x_q <= cx_res.val;
      out_y_q <= cy_res.val;
      out_z_q <= cz_res.val;
      sat_q   <= cx_res.sat | cy_res.sat | cz_res.sat;
    end
  end

  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign saturated_o = sat_q;

endmodule

// File: test/testbench.sv
// Self-checking testbench for euler_vertex_transform_top: random and directed vertices
// against a bit-exact transform predictor. Depends on evt_pkg and the block's RTL only.
module testbench;
  import evt_pkg::*;

  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam logic [CFG_INDEX_W-1:0] REG_UNKNOWN = CFG_INDEX_W'(7);
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_VERTICES = 50;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } vertex_out_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  coord_t                 vertex_x_i = '0;
  coord_t                 vertex_y_i = '0;
  coord_t                 vertex_z_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  coord_t                 out_x_o;
  coord_t                 out_y_o;
  coord_t                 out_z_o;
  logic                   saturated_o;

  // When set, neither side inserts gaps or stalls.
  bit calm = 1'b0;
  int hold_left = 0;

  class transform_scoreboard;
    logic [CFG_REG_W-1:0]  scale [3];
    logic [CFG_REG_W-1:0]  offset [3];
    logic [CFG_DATA_W-1:0] angles;
    longint                sine_q14 [SINE_TABLE_DEPTH+1];
    vertex_out_t           expected_q [$];
    int                    mismatches;

    function new();
      longint t;
      longint t2;
      longint term;
      longint sum;
      longint r;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
        t = (QUARTER_TURN_Q30 * longint'(i)) / longint'(SINE_TABLE_DEPTH);
        t2 = (t * t) / (64'sd1 <<< 30);
        term = t;
        sum = t;
        for (int k = 1; k <= 10; k++) begin
          term = -((term * t2) / (64'sd1 <<< 30));
          term = term / longint'((2 * k) * (2 * k + 1));
          sum += term;
        end
        if (sum < 0) begin
          sum = 0;
        end
        r = (sum + (64'sd1 <<< 15)) >>> 16;
        sine_q14[i] = (r > (64'sd1 <<< TRIG_BITS)) ? (64'sd1 <<< TRIG_BITS) : r;
      end
      for (int j = 0; j < 3; j++) begin
        scale[j] = SCALE_RESET;
        offset[j] = OFFSET_RESET;
      end
      angles = ANGLE_RESET;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_SCALE_X:  scale[0] = data[CFG_REG_W-1:0];
        REG_SCALE_Y:  scale[1] = data[CFG_REG_W-1:0];
        REG_SCALE_Z:  scale[2] = data[CFG_REG_W-1:0];
        REG_OFFSET_X: offset[0] = data[CFG_REG_W-1:0];
        REG_OFFSET_Y: offset[1] = data[CFG_REG_W-1:0];
        REG_OFFSET_Z: offset[2] = data[CFG_REG_W-1:0];
        REG_ANGLES:   angles = data;
        default: ;
      endcase
    endfunction

    function longint sine_of(logic [ANGLE_W-1:0] a);
      longint idx;
      longint mag;
      idx = (longint'(a[ANGLE_FRAC_W-1:0]) * SINE_TABLE_DEPTH) >>> ANGLE_FRAC_W;
      mag = a[ANGLE_W-2] ? sine_q14[SINE_TABLE_DEPTH - idx] : sine_q14[idx];
      return a[ANGLE_W-1] ? -mag : mag;
    endfunction

    function longint cosine_of(logic [ANGLE_W-1:0] a);
      logic [ANGLE_W-1:0] shifted;
      shifted = a + ANGLE_W'(1 << ANGLE_FRAC_W);
      return sine_of(shifted);
    endfunction

    function coord_t clamp(longint val, inout logic sat);
      if (val > longint'(COORD_MAX)) begin
        sat = 1'b1;
        return COORD_MAX;
      end
      if (val < longint'($signed(COORD_MIN))) begin
        sat = 1'b1;
        return COORD_MIN;
      end
      return coord_t'(val);
    endfunction

    function void note_vertex(coord_t x, coord_t y, coord_t z);
      coord_t      c [3];
      longint      v [3];
      longint      sx, cx, sy, cy, sz, cz;
      longint      x1, y1, y2, z2, x3, z3;
      vertex_out_t res;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      for (int j = 0; j < 3; j++) begin
        v[j] = ((longint'(c[j]) * longint'($signed(scale[j]))) >>> FRAC_BITS)
               + longint'($signed(offset[j]));
      end
      sx = sine_of(angles[15:0]);
      cx = cosine_of(angles[15:0]);
      sy = sine_of(angles[31:16]);
      cy = cosine_of(angles[31:16]);
      sz = sine_of(angles[47:32]);
      cz = cosine_of(angles[47:32]);
      x1 = (v[0] * cz - v[1] * sz) >>> TRIG_BITS;
      y1 = (v[0] * sz + v[1] * cz) >>> TRIG_BITS;
      y2 = (y1 * cx - v[2] * sx) >>> TRIG_BITS;
      z2 = (y1 * sx + v[2] * cx) >>> TRIG_BITS;
      x3 = (z2 * sy + x1 * cy) >>> TRIG_BITS;
      z3 = (z2 * cy - x1 * sy) >>> TRIG_BITS;
      res.sat = 1'b0;
      res.x = clamp(x3, res.sat);
      res.y = clamp(y2, res.sat);
      res.z = clamp(z3, res.sat);
      expected_q.push_back(res);
    endfunction

    task check_result(coord_t x, coord_t y, coord_t z, logic sat);
      vertex_out_t exp_v;
      if (expected_q.size() == 0) begin
        report($sformatf("output beat (%0d,%0d,%0d) with no vertex pending", x, y, z));
      end else begin
        exp_v = expected_q.pop_front();
        if (x !== exp_v.x) report($sformatf("out_x %0d, expected %0d", x, exp_v.x));
        if (y !== exp_v.y) report($sformatf("out_y %0d, expected %0d", y, exp_v.y));
        if (z !== exp_v.z) report($sformatf("out_z %0d, expected %0d", z, exp_v.z));
        if (sat !== exp_v.sat) report($sformatf("saturated %b, expected %b", sat, exp_v.sat));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  transform_scoreboard sb;

  euler_vertex_transform_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vertex_x_i  (vertex_x_i),
    .vertex_y_i  (vertex_y_i),
    .vertex_z_i  (vertex_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_x_o, out_y_o, out_z_o, saturated_o);
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      hold_left = pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Valid stays high from one beat to the next unless a gap comes between them.
  task automatic send_vertex(coord_t x, coord_t y, coord_t z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_vertex(x, y, z);
  endtask

  task automatic drain_vertices();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(index, data);
  endtask

  // The sine and cosine registers follow the angle register in the cycle after it changes.
  task automatic cfg_done();
    cfg_valid_i <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  // Upper bits beyond a 16-bit register carry random junk that must be ignored.
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_REG_W-1:0] value);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    return {junk[CFG_DATA_W-1:CFG_REG_W], value};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_angles(logic [ANGLE_W-1:0] ax,
                                                         logic [ANGLE_W-1:0] ay,
                                                         logic [ANGLE_W-1:0] az);
    return {az, ay, ax};
  endfunction

  function automatic logic [CFG_REG_W-1:0] pick_factor(int unity);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r < 4) return CFG_REG_W'($urandom());
    return CFG_REG_W'(unity + $urandom_range(0, 1023) - 512);
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 3) == 0) begin
      return ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
    end
    return ANGLE_W'($urandom());
  endfunction

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    if (r < 4) return coord_t'(int'($urandom_range(0, 2047)) - 1024);
    return coord_t'($urandom());
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values give the identity transform.
    send_vertex(0, 0, 0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(1, -1, 256);
    send_vertex(16'sh5555, -16'sh5556, 16'sh2AAA);
    drain_vertices();

    // Extreme scales and offsets drive every coordinate of the extreme vertices into saturation.
    cfg_write(REG_SCALE_X, with_junk(16'h7FFF));
    cfg_write(REG_SCALE_Y, with_junk(16'h8000));
    cfg_write(REG_SCALE_Z, with_junk(16'h8000));
    cfg_write(REG_OFFSET_X, with_junk(16'h7FFF));
    cfg_write(REG_OFFSET_Y, with_junk(16'h8000));
    cfg_write(REG_OFFSET_Z, with_junk(16'h0100));
    cfg_write(REG_ANGLES, pack_angles(0, 0, 0));
    cfg_write(REG_UNKNOWN, {$urandom(), $urandom()});
    cfg_done();
    send_vertex(COORD_MAX, COORD_MAX, COORD_MIN);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MAX);
    send_vertex(0, 0, 0);
    drain_vertices();

    // Quadrant boundaries of the angles, then the last step below a quarter, a half and a full turn.
    cfg_write(REG_SCALE_X, with_junk(SCALE_RESET));
    cfg_write(REG_SCALE_Y, with_junk(SCALE_RESET));
    cfg_write(REG_SCALE_Z, with_junk(SCALE_RESET));
    cfg_write(REG_OFFSET_X, with_junk(OFFSET_RESET));
    cfg_write(REG_OFFSET_Y, with_junk(OFFSET_RESET));
    cfg_write(REG_OFFSET_Z, with_junk(OFFSET_RESET));
    cfg_write(REG_ANGLES, pack_angles(16'hC000, 16'h8000, 16'h4000));
    cfg_done();
    send_vertex(16'sh1000, 16'sh0200, -16'sh0300);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX);
    drain_vertices();
    cfg_write(REG_ANGLES, pack_angles(16'hFFFF, 16'h3FFF, 16'h7FFF));
    cfg_done();
    send_vertex(16'sh1000, 16'sh0200, -16'sh0300);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN);
    drain_vertices();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      cfg_write(REG_SCALE_X, with_junk(pick_factor(256)));
      cfg_write(REG_SCALE_Y, with_junk(pick_factor(256)));
      cfg_write(REG_SCALE_Z, with_junk(pick_factor(256)));
      cfg_write(REG_OFFSET_X, with_junk(pick_factor(0)));
      cfg_write(REG_OFFSET_Y, with_junk(pick_factor(0)));
      cfg_write(REG_OFFSET_Z, with_junk(pick_factor(0)));
      cfg_write(REG_ANGLES, pack_angles(pick_angle(), pick_angle(), pick_angle()));
      if ($urandom_range(0, 1) == 1) begin
        cfg_write(REG_UNKNOWN, {$urandom(), $urandom()});
      end
      cfg_done();
      for (int n = 0; n < PHASE_VERTICES; n++) begin
        send_vertex(pick_coord(), pick_coord(), pick_coord());
      end
      drain_vertices();
    end

    calm = 1'b0;
    repeat (2 * NUM_STAGES + 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/evt_pkg.sv
rtl/core/evt_sincos.sv
rtl/core/evt_front.sv
rtl/core/evt_back.sv
rtl/core/euler_vertex_transform_top.sv
test/testbench.sv
